[sv/acae_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and width helpers of the current amplitude estimator.
package acae_pkg;

  localparam int unsigned ADC_BITS_DEF  = 10;
  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_ZERO_CODE    = 2'd0,
    REG_GAIN_Q8      = 2'd1,
    REG_NOISE_OFFSET = 2'd2
  } acae_reg_e;

  localparam logic [15:0] ZERO_CODE_RST    = 16'd517;
  localparam logic [15:0] GAIN_Q8_RST      = 16'd9001;
  localparam logic [13:0] NOISE_OFFSET_RST = 14'd100;

  typedef struct packed {
    logic [15:0] zero_code;
    logic [15:0] gain_q8;
    logic [13:0] noise_offset_ma;
  } acae_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_RES  = 4'b1000
  } acae_state_e;

  // Average datapath: 32-bit filter state, 36-bit offset numerator for the divide by ten
  localparam int unsigned EMA_W    = 32;
  localparam int unsigned ACC_W    = 36;
  localparam int unsigned DIV_STEP = 18;
  localparam int unsigned DIV_CNT  = ACC_W / DIV_STEP;
  localparam int unsigned DIV_BASE = 10;
  // floor(y / 10) == (y * DIV_RECIP) >> DIV_SHIFT for every y below 2^(DIV_STEP+4)
  localparam int unsigned DIV_SHIFT = 26;
  localparam longint      DIV_RECIP = 64'sd6710887;
  // 10 * 2^31: numerator offset that maps the saturated range onto [0, 2*span)
  localparam longint EMA_SPAN = 64'sd21474836480;

  function automatic int unsigned prod_width(int unsigned adc_bits);
    return adc_bits + 18;
  endfunction

  function automatic int unsigned cur_width(int unsigned adc_bits, int unsigned frac_bits);
    return adc_bits + 18 + ((frac_bits > 8) ? (frac_bits - 8) : 0);
  endfunction

  function automatic int unsigned num_width(int unsigned cw);
    return ((cw > ACC_W) ? cw : ACC_W) + 2;
  endfunction

endpackage

[sv/acae_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels for ADC sample items and amplitude result items.
interface acae_in_if #(
  parameter int unsigned ADC_BITS = acae_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample;
  logic                window_last;

  modport source (output valid, output sample, output window_last, input ready);
  modport sink   (input valid, input sample, input window_last, output ready);
endinterface

interface acae_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] amplitude_ma;

  modport source (output valid, output amplitude_ma, input ready);
  modport sink   (input valid, input amplitude_ma, output ready);
endinterface

[sv/acae_regs.sv]
`timescale 1ns / 1ps
// APB configuration registers: zero code, gain and noise offset.
module acae_regs #(
  parameter int unsigned ADC_BITS = acae_pkg::ADC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acae_pkg::APB_AW-1:0]   paddr,
  input  logic [acae_pkg::APB_DW-1:0]   pwdata,
  output logic [acae_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output acae_pkg::acae_cfg_t           cfg_o
);

  logic [ADC_BITS-1:0] zero_code_q;
  logic [15:0]         gain_q8_q;
  logic [13:0]         noise_offset_q;
  logic                wr_en;
  acae_pkg::acae_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = acae_pkg::acae_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_code_q    <= ADC_BITS'(acae_pkg::ZERO_CODE_RST);
      gain_q8_q      <= acae_pkg::GAIN_Q8_RST;
      noise_offset_q <= acae_pkg::NOISE_OFFSET_RST;
    end else if (wr_en) begin
      case (reg_sel)
        acae_pkg::REG_ZERO_CODE:    zero_code_q    <= pwdata[ADC_BITS-1:0];
        acae_pkg::REG_GAIN_Q8:      gain_q8_q      <= pwdata[15:0];
        acae_pkg::REG_NOISE_OFFSET: noise_offset_q <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      acae_pkg::REG_ZERO_CODE:    prdata = acae_pkg::APB_DW'(zero_code_q);
      acae_pkg::REG_GAIN_Q8:      prdata = acae_pkg::APB_DW'(gain_q8_q);
      acae_pkg::REG_NOISE_OFFSET: prdata = acae_pkg::APB_DW'(noise_offset_q);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.zero_code       = 16'(zero_code_q);
  assign cfg_o.gain_q8         = gain_q8_q;
  assign cfg_o.noise_offset_ma = noise_offset_q;

endmodule

[sv/acae_front.sv]
`timescale 1ns / 1ps
// Front end: accept samples, scale them to current and hand them to the queue.
module acae_front #(
  parameter int unsigned ADC_BITS  = acae_pkg::ADC_BITS_DEF,
  parameter int unsigned FRAC_BITS = acae_pkg::FRAC_BITS_DEF,
  localparam int unsigned CW       = acae_pkg::cur_width(ADC_BITS, FRAC_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  acae_in_if.sink             item_i,
  input  acae_pkg::acae_cfg_t cfg_i,
  output logic                push_valid_o,
  output logic [CW-1:0]       push_cur_o,
  output logic                push_last_o,
  input  logic                push_ready_i
);

  localparam int unsigned PW = acae_pkg::prod_width(ADC_BITS);

  logic signed [ADC_BITS:0] diff;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     prod_q;
  logic                     last_q;
  logic                     valid_q;
  logic signed [CW-1:0]     cur;
  logic                     take;

  assign diff = $signed({1'b0, item_i.sample}) -
                $signed({1'b0, cfg_i.zero_code[ADC_BITS-1:0]});
  assign prod = $signed({1'b0, cfg_i.gain_q8}) * diff;

  assign item_i.ready = !valid_q || push_ready_i;
  assign take         = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= prod;
      last_q <= item_i.window_last;
    end
  end

  // Bring the Q8 product to FRAC_BITS fraction bits; narrowing rounds half up
  if (FRAC_BITS >= 8) begin : g_widen
    assign cur = CW'(prod_q) <<< (FRAC_BITS - 8);
  end else begin : g_round
    localparam logic signed [PW-1:0] Rnd = PW'(1) << (7 - FRAC_BITS);
    logic signed [PW-1:0] rnd_sum;
    assign rnd_sum = prod_q + Rnd;
    assign cur     = CW'(rnd_sum >>> (8 - FRAC_BITS));
  end

  assign push_valid_o = valid_q;
  assign push_cur_o   = cur;
  assign push_last_o  = last_q;

endmodule

[sv/acae_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue that decouples the scaling front end from the filter back end.
module acae_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  logic [DW-1:0] push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output logic [DW-1:0] pop_data_o,
  input  logic          pop_ready_i
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count did not advance on push");

endmodule

[sv/acae_back.sv]
`timescale 1ns / 1ps
// Back end: moving average with a reciprocal-multiply divide by ten, peak tracking and result.
module acae_back #(
  parameter int unsigned ADC_BITS  = acae_pkg::ADC_BITS_DEF,
  parameter int unsigned FRAC_BITS = acae_pkg::FRAC_BITS_DEF,
  localparam int unsigned CW       = acae_pkg::cur_width(ADC_BITS, FRAC_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  logic [CW-1:0]       pop_cur_i,
  input  logic                pop_last_i,
  output logic                pop_ready_o,
  input  acae_pkg::acae_cfg_t cfg_i,
  acae_out_if.source          result_o
);

  localparam int unsigned NW    = acae_pkg::num_width(CW);
  localparam int unsigned AW    = acae_pkg::ACC_W;
  localparam int unsigned EW    = acae_pkg::EMA_W;
  localparam int unsigned STEP  = acae_pkg::DIV_STEP;
  localparam int unsigned YW    = STEP + 4;
  localparam int unsigned MW    = YW + 1;
  localparam int unsigned Shift = acae_pkg::DIV_SHIFT;
  localparam int unsigned CNT_W = $clog2(acae_pkg::DIV_CNT);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(acae_pkg::DIV_CNT - 1);
  localparam logic signed [NW-1:0] Span   = NW'(acae_pkg::EMA_SPAN);
  localparam logic signed [NW-1:0] SpanM1 = NW'(acae_pkg::EMA_SPAN - 1);
  localparam logic signed [NW-1:0] Rnd5   = NW'(5);
  localparam logic [AW-1:0] AccMax = AW'(2 * acae_pkg::EMA_SPAN - 1);
  localparam logic [MW-1:0] Recip  = MW'(acae_pkg::DIV_RECIP);
  localparam logic [YW-1:0] Base   = YW'(acae_pkg::DIV_BASE);

  acae_pkg::acae_state_e state_q, state_d;

  logic signed [EW-1:0] ema_q, high_q, low_q, ema_new;
  logic [AW-1:0]        acc_q, quo_q;
  logic [3:0]           rem_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 last_q;
  logic                 out_valid_q;
  logic signed [15:0]   amp_q;

  logic signed [NW-1:0] ema_x, cur_x, num;
  logic [AW-1:0]        acc_load;
  logic [YW-1:0]        div_y;
  logic [YW+MW-1:0]     div_prod;
  logic [STEP-1:0]      qd;
  logic [YW-1:0]        qd_x10;
  logic [3:0]           rem_nxt;
  logic                 out_free;
  logic signed [32:0]   swing;
  logic [33:0]          swing_rnd;
  logic signed [34:0]   amp_wide;
  logic signed [15:0]   amp_sat;

  assign pop_ready_o = (state_q == acae_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || result_o.ready;

  // Numerator 9*ema + cur + 5, clamped to the saturation range and offset to be nonnegative
  assign ema_x = NW'(ema_q);
  assign cur_x = NW'($signed(pop_cur_i));
  assign num   = (ema_x <<< 3) + ema_x + cur_x + Rnd5;

  always_comb begin
    if (num > SpanM1) begin
      acc_load = AccMax;
    end else if (num < -Span) begin
      acc_load = '0;
    end else begin
      acc_load = AW'(num + Span);
    end
  end

  // One 18-bit quotient digit per cycle, most significant first: reciprocal multiply,
  // then carry the remainder into the next digit
  assign div_y    = {rem_q, acc_q[AW-1 -: STEP]};
  assign div_prod = {{MW{1'b0}}, div_y} * {{YW{1'b0}}, Recip};
  assign qd       = div_prod[Shift +: STEP];
  assign qd_x10   = YW'(qd) * Base;
  assign rem_nxt  = 4'(div_y - qd_x10);

  // Quotient carries a 2^31 offset: flip the sign bit to recover the average
  assign ema_new = $signed({!quo_q[EW-1], quo_q[EW-2:0]});

  assign swing     = 33'(high_q) - 33'(low_q);
  assign swing_rnd = 34'($unsigned(swing)) + (34'(1) << FRAC_BITS);
  assign amp_wide  = $signed({1'b0, swing_rnd >> (FRAC_BITS + 1)}) -
                     $signed(35'(cfg_i.noise_offset_ma));

  always_comb begin
    if (amp_wide > 35'sd32767) begin
      amp_sat = 16'sh7FFF;
    end else if (amp_wide < -35'sd32768) begin
      amp_sat = -16'sh8000;
    end else begin
      amp_sat = amp_wide[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      acae_pkg::ST_IDLE: if (pop_valid_i) state_d = acae_pkg::ST_DIV;
      acae_pkg::ST_DIV:  if (cnt_q == CntLast) state_d = acae_pkg::ST_UPD;
      acae_pkg::ST_UPD:  state_d = last_q ? acae_pkg::ST_RES : acae_pkg::ST_IDLE;
      acae_pkg::ST_RES:  if (out_free) state_d = acae_pkg::ST_IDLE;
      default:           state_d = acae_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acae_pkg::ST_IDLE;
      ema_q       <= '0;
      high_q      <= '0;
      low_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        acae_pkg::ST_IDLE: cnt_q <= '0;
        acae_pkg::ST_DIV:  cnt_q <= cnt_q + CNT_W'(1);
        acae_pkg::ST_UPD: begin
          ema_q <= ema_new;
          if (ema_new > high_q) high_q <= ema_new;
          if (ema_new < low_q)  low_q  <= ema_new;
        end
        acae_pkg::ST_RES: begin
          // Clear the window state once the result is loaded
          if (out_free) begin
            ema_q  <= '0;
            high_q <= '0;
            low_q  <= '0;
          end
        end
        default: ;
      endcase
      if (state_q == acae_pkg::ST_RES && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acae_pkg::ST_IDLE && pop_valid_i) begin
      acc_q  <= acc_load;
      quo_q  <= '0;
      rem_q  <= '0;
      last_q <= pop_last_i;
    end else if (state_q == acae_pkg::ST_DIV) begin
      acc_q <= acc_q << STEP;
      quo_q <= {quo_q[AW-STEP-1:0], qd};
      rem_q <= rem_nxt;
    end
    if (state_q == acae_pkg::ST_RES && out_free) begin
      amp_q <= amp_sat;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.amplitude_ma = amp_q;

  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_q >= low_q && high_q >= 0 && low_q <= 0)
    else $error("peak registers out of order");

  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == acae_pkg::ST_RES |-> last_q)
    else $error("result state entered without window end");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == acae_pkg::ST_RES))
    else $error("result raised outside result state");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == acae_pkg::ST_UPD |-> $past(state_q == acae_pkg::ST_DIV && cnt_q == CntLast))
    else $error("divide ended early");

endmodule

[sv/ac_current_amplitude_estimator.sv]
`timescale 1ns / 1ps
// Current amplitude estimator: takes ADC samples of a Hall current sensor and reports
// half the peak-to-peak swing of their moving average once per measurement window.
//
// Channels: item_i carries one ADC sample and a window_last flag per item; result_o
// carries one signed amplitude in whole mA for each item with window_last set.
// Both use valid/ready; an item moves on a clock edge with both high.
// Configuration (zero code, gain, noise offset) is written over the APB port at byte
// addresses 0, 4 and 8; pready is always high and reads return the register value.
// The filter loop limits throughput: its divide by ten takes two 18-bit reciprocal-multiply
// steps, and the back end takes no new item until it is through with the last one.
// The last item of a window passes the front-end product register and the queue, then
// the back end's load, divide, update and result states before the result register is valid.
// The front end registers the scaling product and a two-entry queue buffers scaled
// currents, so up to three items are taken while the back end is busy.
// Reset clears the average and both peaks, restores register defaults, and empties
// the queue and the result register. A stalled receiver holds the result register;
// the back end then waits before loading the next window result.
module ac_current_amplitude_estimator #(
  parameter int unsigned ADC_BITS  = acae_pkg::ADC_BITS_DEF,
  parameter int unsigned FRAC_BITS = acae_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  acae_in_if.sink                     item_i,
  acae_out_if.source                  result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acae_pkg::APB_AW-1:0] paddr,
  input  logic [acae_pkg::APB_DW-1:0] pwdata,
  output logic [acae_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned CW = acae_pkg::cur_width(ADC_BITS, FRAC_BITS);

  acae_pkg::acae_cfg_t cfg;
  logic                push_valid, push_ready, push_last;
  logic [CW-1:0]       push_cur;
  logic                pop_valid, pop_ready;
  logic [CW:0]         pop_data;

  acae_regs #(
    .ADC_BITS (ADC_BITS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  acae_front #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_i        (cfg),
    .push_valid_o (push_valid),
    .push_cur_o   (push_cur),
    .push_last_o  (push_last),
    .push_ready_i (push_ready)
  );

  acae_queue #(
    .DW (CW + 1)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  ({push_last, push_cur}),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  acae_back #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cur_i   (pop_data[CW-1:0]),
    .pop_last_i  (pop_data[CW]),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg),
    .result_o    (result_o)
  );

endmodule

[verif/ac_current_amplitude_estimator_tb.sv]
`timescale 1ns / 1ps
// Testbench of the current amplitude estimator: directed and random windows checked against a predictor.
module ac_current_amplitude_estimator_tb;

  localparam int unsigned ADC_BITS = acae_pkg::ADC_BITS_DEF;
  localparam int unsigned FRAC     = acae_pkg::FRAC_BITS_DEF;
  localparam int unsigned AW       = acae_pkg::APB_AW;
  localparam int unsigned DW       = acae_pkg::APB_DW;
  localparam int          ADC_MAX  = (1 << ADC_BITS) - 1;
  localparam int          IDLE_LIMIT  = 5000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          SETTLE      = 100;

  class amplitude_scoreboard;
    logic [ADC_BITS-1:0] zero_code;
    logic [15:0]         gain_q8;
    logic [13:0]         noise_ma;
    longint              ema;
    longint              peak_hi;
    longint              peak_lo;
    logic signed [15:0]  amp_q[$];
    int                  errors;

    function new();
      zero_code = ADC_BITS'(acae_pkg::ZERO_CODE_RST);
      gain_q8   = acae_pkg::GAIN_Q8_RST;
      noise_ma  = acae_pkg::NOISE_OFFSET_RST;
      ema       = 0;
      peak_hi   = 0;
      peak_lo   = 0;
      errors    = 0;
    endfunction

    function void log_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function int pending();
      return amp_q.size();
    endfunction

    // Advance the average and both peaks by one accepted sample; queue the expected amplitude at a window end.
    function void note_input(logic [ADC_BITS-1:0] s, logic last);
      longint g, z, sv, cur, num, q, d, half, a;
      g   = gain_q8;
      z   = zero_code;
      sv  = s;
      cur = (g * (sv - z)) <<< (FRAC - 8);
      num = 9 * ema + cur + 5;
      q   = num / 10;
      if (num % 10 < 0) q--;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      ema = q;
      if (ema > peak_hi) peak_hi = ema;
      if (ema < peak_lo) peak_lo = ema;
      if (last) begin
        d    = peak_hi - peak_lo;
        half = (d + (64'sd1 <<< FRAC)) / (64'sd2 <<< FRAC);
        a    = half - longint'(noise_ma);
        if (a > 32767) a = 32767;
        if (a < -32768) a = -32768;
        amp_q.push_back(a[15:0]);
        ema     = 0;
        peak_hi = 0;
        peak_lo = 0;
      end
    endfunction

    function void check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (amp_q.size() == 0) begin
        log_mismatch($sformatf("unexpected amplitude %0d", got));
      end else begin
        want = amp_q.pop_front();
        if (got !== want)
          log_mismatch($sformatf("amplitude mismatch: expected %0d, got %0d", want, got));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AW-1:0]       paddr;
  logic [DW-1:0]       pwdata;
  logic [DW-1:0]       prdata;
  logic                pready;

  acae_in_if #(.ADC_BITS(ADC_BITS)) in_if ();
  acae_out_if                       out_if ();

  ac_current_amplitude_estimator #(
    .ADC_BITS (ADC_BITS),
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_if),
    .result_o(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  amplitude_scoreboard sb = new();
  bit tx_burst;
  bit hold_req;
  int idle_cycles;

  always #5 clk_i = ~clk_i;

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ac_current_amplitude_estimator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input acae_pkg::acae_reg_e idx, input logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input acae_pkg::acae_reg_e idx, output logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input acae_pkg::acae_reg_e idx, input logic [DW-1:0] want);
    logic [DW-1:0] got;
    apb_read(idx, got);
    if (got !== want)
      sb.log_mismatch($sformatf("register %s reads %0d, expected %0d", idx.name(), got, want));
  endtask

  task automatic set_config(input int zc, input int gain, input int noise);
    apb_write(acae_pkg::REG_ZERO_CODE, zc);
    apb_write(acae_pkg::REG_GAIN_Q8, gain);
    apb_write(acae_pkg::REG_NOISE_OFFSET, noise);
    sb.zero_code = ADC_BITS'(zc);
    sb.gain_q8   = 16'(gain);
    sb.noise_ma  = 14'(noise);
    check_reg(acae_pkg::REG_ZERO_CODE, zc);
    check_reg(acae_pkg::REG_GAIN_Q8, gain);
    check_reg(acae_pkg::REG_NOISE_OFFSET, noise);
  endtask

  // Hold valid across back-to-back items; lower it only when a gap is drawn.
  task automatic send_item(input int s, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s[ADC_BITS-1:0];
    in_if.window_last <= last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_input(s[ADC_BITS-1:0], last);
  endtask

  // Drop valid, collect every result, then let queued non-final items retire.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n_items, input bit pressure);
    int sent, len, shape, swing, period, off, v, k;
    sent = 0;
    if (pressure) hold_req = 1'b1;
    while (sent < n_items) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      shape  = $urandom_range(0, 3);
      swing  = $urandom_range(0, ADC_MAX / 2);
      period = $urandom_range(2, 16);
      tx_burst = pressure || ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
        if (shape == 0) begin
          v = $urandom_range(0, ADC_MAX);
        end else begin
          // Square wave around the zero code with a little jitter.
          off = ((k % period) < period / 2) ? swing : -swing;
          v   = int'(sb.zero_code) + off + $urandom_range(0, 8) - 4;
          if (v < 0) v = 0;
          if (v > ADC_MAX) v = ADC_MAX;
        end
        send_item(v, k == len - 1);
      end
      sent += len;
    end
    tx_burst = 1'b0;
    drain();
  endtask

  // Receiver: random stalls, stretches without stalls, and one long hold on request.
  initial begin
    int gap, n_seen;
    bit rx_burst;
    bit hold_done;
    out_if.ready <= 1'b0;
    n_seen    = 0;
    rx_burst  = 1'b0;
    hold_done = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (n_seen % 8 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        gap = rx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      sb.check_result(out_if.amplitude_ma);
      n_seen++;
    end
  end

  initial begin
    int ph;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.window_last <= 1'b0;
    tx_burst          = 1'b0;
    hold_req          = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reg(acae_pkg::REG_ZERO_CODE, DW'(acae_pkg::ZERO_CODE_RST));
    check_reg(acae_pkg::REG_GAIN_Q8, DW'(acae_pkg::GAIN_Q8_RST));
    check_reg(acae_pkg::REG_NOISE_OFFSET, DW'(acae_pkg::NOISE_OFFSET_RST));

    // Reset settings: zero current, one-sample windows, full-scale swing, codes around the zero code.
    send_item(517, 1'b1);
    send_item(ADC_MAX, 1'b0);
    send_item(ADC_MAX, 1'b0);
    send_item(0, 1'b0);
    send_item(0, 1'b1);
    send_item(0, 1'b1);
    send_item(516, 1'b0);
    send_item(518, 1'b1);
    drain();

    // Top gain from code zero: the amplitude saturates high.
    set_config(0, 65535, 0);
    repeat (4) send_item(ADC_MAX, 1'b0);
    send_item(0, 1'b1);
    send_item(ADC_MAX, 1'b1);
    drain();

    // Zero code at the top, offset 10000: large negative currents; the one-sample window gives a negative amplitude.
    set_config(ADC_MAX, 65535, 10000);
    repeat (3) send_item(0, 1'b0);
    send_item(ADC_MAX, 1'b1);
    send_item(ADC_MAX, 1'b1);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(int'(acae_pkg::ZERO_CODE_RST), int'(acae_pkg::GAIN_Q8_RST),
                      int'(acae_pkg::NOISE_OFFSET_RST));
        1: set_config(0, 0, 10000);
        2: set_config(ADC_MAX, 65535, 0);
        3: set_config(512, 1, 0);
        default: set_config($urandom_range(0, ADC_MAX), $urandom_range(0, 65535),
                            $urandom_range(0, 10000));
      endcase
      random_phase(150, ph == 3);
    end

    if (sb.errors == 0) $display("ac_current_amplitude_estimator test passed");
    else $display("ac_current_amplitude_estimator test failed");
    $finish;
  end

endmodule
